// ===== src/spte_pkg.sv =====
// Package with the shared types, codes and the CRC-8 step function.
`timescale 1ns / 1ps
package spte_pkg;

	typedef struct packed {
		logic [2:0] func;
		logic [2:0] kind;
		logic [6:0] target_address;
		logic [7:0] command_code;
		logic [7:0] byte_value;
		logic [7:0] block_length;
		logic [7:0] read_limit;
		logic       nacked;
	} in_beat_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [6:0] bus_address;
		logic       read_direction;
		logic [8:0] transfer_count;
		logic       auto_stop;
		logic [7:0] out_byte;
		logic [2:0] status;
		logic       last;
	} out_beat_t;

	// Event codes.
	localparam logic [2:0] FUNC_START = 3'd0;
	localparam logic [2:0] FUNC_DATA  = 3'd1;
	localparam logic [2:0] FUNC_ACK   = 3'd2;
	localparam logic [2:0] FUNC_RX    = 3'd3;
	localparam logic [2:0] FUNC_TICK  = 3'd4;

	// Result kinds.
	localparam logic [1:0] RK_START  = 2'd0;
	localparam logic [1:0] RK_TX     = 2'd1;
	localparam logic [1:0] RK_RXDATA = 2'd2;
	localparam logic [1:0] RK_STATUS = 2'd3;

	// Status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NACK     = 3'd1;
	localparam logic [2:0] ST_TIMEOUT  = 3'd2;
	localparam logic [2:0] ST_PEC      = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	// Transaction kinds.
	localparam logic [2:0] K_SEND   = 3'd0;
	localparam logic [2:0] K_WRBYTE = 3'd1;
	localparam logic [2:0] K_RDBYTE = 3'd2;
	localparam logic [2:0] K_WRWORD = 3'd3;
	localparam logic [2:0] K_RDWORD = 3'd4;
	localparam logic [2:0] K_BLKWR  = 3'd5;
	localparam logic [2:0] K_BLKRD  = 3'd6;
	localparam logic [2:0] K_BWBR   = 3'd7;

	localparam logic [15:0] WAIT_LIMIT_RESET = 16'd10000;

	// Two result beats per event at most, plus a count.
	typedef struct packed {
		logic [1:0] n;
		out_beat_t  r0;
		out_beat_t  r1;
	} res_pair_t;

	// One CRC-8 step, polynomial x^8+x^2+x+1.
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
		end
		return c;
	endfunction

endpackage

// ===== src/spte_front.sv =====
// Front part: takes event beats, runs the transaction sequencer, emits result pairs.
`timescale 1ns / 1ps
module spte_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  spte_pkg::in_beat_t  in_data,
	input  logic [15:0]         wait_limit,
	output logic                pair_valid,
	input  logic                pair_ready,
	output spte_pkg::res_pair_t pair_data
);
	import spte_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE, PH_ACK_CMD, PH_WAIT_DATA, PH_ACK_DATA, PH_ACK_PEC,
		PH_RX_COUNT, PH_RX_DATA, PH_RX_PEC
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [2:0] kind_q, kind_d;
	logic [6:0] addr_q, addr_d;
	logic [7:0] pec_q, pec_d;
	logic [7:0] left_q, left_d;
	logic [7:0] limit_q, limit_d;
	logic [15:0] wait_q, wait_d;
	res_pair_t  res;
	logic       ack_wait, rx_wait;
	logic [15:0] wait_inc;
	logic [7:0] rd_addr_byte;

	function automatic out_beat_t mk(input logic [1:0] rk, input logic [6:0] a,
		input logic rd, input logic [8:0] cnt, input logic stp, input logic [7:0] b,
		input logic [2:0] st, input logic lst);
		out_beat_t o;
		o.result_kind = rk; o.bus_address = a; o.read_direction = rd;
		o.transfer_count = cnt; o.auto_stop = stp; o.out_byte = b;
		o.status = st; o.last = lst;
		return o;
	endfunction

	// Accept whenever the queue has room; one event per cycle.
	assign in_ready   = pair_ready;
	assign pair_valid = in_valid && in_ready;
	assign pair_data  = res;

	// Next-state and result logic, mirroring one event step.
	always_comb begin
		ack_wait = (phase_q == PH_ACK_CMD) || (phase_q == PH_ACK_DATA) || (phase_q == PH_ACK_PEC);
		rx_wait  = (phase_q == PH_RX_COUNT) || (phase_q == PH_RX_DATA) || (phase_q == PH_RX_PEC);
		wait_inc = wait_q + 16'd1;
		rd_addr_byte = {addr_q, 1'b1};
		phase_d = phase_q; kind_d = kind_q; addr_d = addr_q; pec_d = pec_q;
		left_d = left_q; limit_d = limit_q; wait_d = wait_q;
		res = '0;
		case (in_data.func)
			FUNC_START: begin
				if (phase_q == PH_IDLE) begin
					kind_d = in_data.kind; addr_d = in_data.target_address;
					limit_d = in_data.read_limit; left_d = in_data.block_length;
					wait_d = '0;
					res.n = 2'd2;
					case (in_data.kind)
						K_SEND:   res.r0 = mk(RK_START, in_data.target_address, 1'b0, 9'd2, 1'b1, 8'd0, ST_OK, 1'b0);
						K_WRBYTE: res.r0 = mk(RK_START, in_data.target_address, 1'b0, 9'd3, 1'b1, 8'd0, ST_OK, 1'b0);
						K_WRWORD: res.r0 = mk(RK_START, in_data.target_address, 1'b0, 9'd4, 1'b1, 8'd0, ST_OK, 1'b0);
						K_BLKWR:  res.r0 = mk(RK_START, in_data.target_address, 1'b0,
							{1'b0, in_data.block_length} + 9'd3, 1'b1, 8'd0, ST_OK, 1'b0);
						K_BWBR:   res.r0 = mk(RK_START, in_data.target_address, 1'b0,
							{1'b0, in_data.block_length} + 9'd3, 1'b0, 8'd0, ST_OK, 1'b0);
						default:  res.r0 = mk(RK_START, in_data.target_address, 1'b0, 9'd1, 1'b0, 8'd0, ST_OK, 1'b0);
					endcase
					res.r1 = mk(RK_TX, 7'd0, 1'b0, 9'd0, 1'b0, in_data.command_code, ST_OK, 1'b0);
					pec_d = crc8_step(crc8_step(8'd0, {in_data.target_address, 1'b0}),
						in_data.command_code);
					phase_d = PH_ACK_CMD;
				end
			end
			FUNC_TICK: begin
				if (ack_wait || rx_wait) begin
					wait_d = wait_inc;
					if (wait_inc >= wait_limit) begin
						res.n = 2'd1;
						res.r0 = mk(RK_STATUS, 7'd0, 1'b0, 9'd0, 1'b0, 8'd0, ST_TIMEOUT, 1'b1);
						phase_d = PH_IDLE; wait_d = '0;
					end
				end
			end
			FUNC_ACK: begin
				if (in_data.nacked && (ack_wait || rx_wait)) begin
					res.n = 2'd1;
					res.r0 = mk(RK_STATUS, 7'd0, 1'b0, 9'd0, 1'b0, 8'd0, ST_NACK, 1'b1);
					phase_d = PH_IDLE; wait_d = '0;
				end else if (ack_wait) begin
					wait_d = '0;
					if (phase_q == PH_ACK_CMD) begin
						case (kind_q)
							K_SEND: begin
								res.n = 2'd1;
								res.r0 = mk(RK_TX, 7'd0, 1'b0, 9'd0, 1'b0, pec_q, ST_OK, 1'b0);
								phase_d = PH_ACK_PEC;
							end
							K_WRBYTE: begin left_d = 8'd1; phase_d = PH_WAIT_DATA; end
							K_WRWORD: begin left_d = 8'd2; phase_d = PH_WAIT_DATA; end
							K_BLKWR, K_BWBR: begin
								res.n = 2'd1;
								res.r0 = mk(RK_TX, 7'd0, 1'b0, 9'd0, 1'b0, left_q, ST_OK, 1'b0);
								pec_d = crc8_step(pec_q, left_q);
								phase_d = PH_ACK_DATA;
							end
							K_RDBYTE: begin
								left_d = 8'd1; res.n = 2'd1;
								res.r0 = mk(RK_START, addr_q, 1'b1, 9'd2, 1'b1, 8'd0, ST_OK, 1'b0);
								pec_d = crc8_step(pec_q, rd_addr_byte);
								phase_d = PH_RX_DATA;
							end
							K_RDWORD: begin
								left_d = 8'd2; res.n = 2'd1;
								res.r0 = mk(RK_START, addr_q, 1'b1, 9'd3, 1'b1, 8'd0, ST_OK, 1'b0);
								pec_d = crc8_step(pec_q, rd_addr_byte);
								phase_d = PH_RX_DATA;
							end
							default: begin
								res.n = 2'd1;
								res.r0 = mk(RK_START, addr_q, 1'b1, 9'd1, 1'b0, 8'd0, ST_OK, 1'b0);
								pec_d = crc8_step(pec_q, rd_addr_byte);
								phase_d = PH_RX_COUNT;
							end
						endcase
					end else if (phase_q == PH_ACK_DATA) begin
						if (left_q != 8'd0) begin
							phase_d = PH_WAIT_DATA;
						end else begin
							res.n = 2'd1;
							res.r0 = mk(RK_TX, 7'd0, 1'b0, 9'd0, 1'b0, pec_q, ST_OK, 1'b0);
							phase_d = PH_ACK_PEC;
						end
					end else if (kind_q == K_BWBR) begin
						// Read phase PEC restarts at the read address.
						res.n = 2'd1;
						res.r0 = mk(RK_START, addr_q, 1'b1, 9'd1, 1'b0, 8'd0, ST_OK, 1'b0);
						pec_d = crc8_step(8'd0, rd_addr_byte);
						phase_d = PH_RX_COUNT;
					end else begin
						res.n = 2'd1;
						res.r0 = mk(RK_STATUS, 7'd0, 1'b0, 9'd0, 1'b0, 8'd0, ST_OK, 1'b1);
						phase_d = PH_IDLE; wait_d = '0;
					end
				end
			end
			FUNC_DATA: begin
				if (phase_q == PH_WAIT_DATA) begin
					left_d = left_q - 8'd1;
					res.n = 2'd1;
					res.r0 = mk(RK_TX, 7'd0, 1'b0, 9'd0, 1'b0, in_data.byte_value, ST_OK, 1'b0);
					pec_d = crc8_step(pec_q, in_data.byte_value);
					phase_d = PH_ACK_DATA;
				end
			end
			FUNC_RX: begin
				if (rx_wait) begin
					wait_d = '0;
					res.n = 2'd1;
					if (phase_q == PH_RX_PEC) begin
						res.r0 = mk(RK_STATUS, 7'd0, 1'b0, 9'd0, 1'b0, 8'd0,
							(in_data.byte_value == pec_q) ? ST_OK : ST_PEC, 1'b1);
						phase_d = PH_IDLE;
					end else begin
						pec_d = crc8_step(pec_q, in_data.byte_value);
						if (phase_q == PH_RX_COUNT) begin
							if (in_data.byte_value > limit_q) begin
								res.r0 = mk(RK_STATUS, 7'd0, 1'b0, 9'd0, 1'b0, 8'd0, ST_OVERFLOW, 1'b1);
								phase_d = PH_IDLE;
							end else begin
								left_d = in_data.byte_value;
								res.r0 = mk(RK_START, addr_q, 1'b1,
									{1'b0, in_data.byte_value} + 9'd1, 1'b1, 8'd0, ST_OK, 1'b0);
								phase_d = (in_data.byte_value != 8'd0) ? PH_RX_DATA : PH_RX_PEC;
							end
						end else begin
							res.r0 = mk(RK_RXDATA, 7'd0, 1'b0, 9'd0, 1'b0, in_data.byte_value, ST_OK, 1'b0);
							left_d = left_q - 8'd1;
							if (left_q == 8'd1) phase_d = PH_RX_PEC;
						end
					end
				end
			end
			default: ;
		endcase
	end

	// Transaction state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; kind_q <= '0; addr_q <= '0; pec_q <= '0;
			left_q <= '0; limit_q <= '0; wait_q <= '0;
		end else if (in_valid && in_ready) begin
			phase_q <= phase_d; kind_q <= kind_d; addr_q <= addr_d; pec_q <= pec_d;
			left_q <= left_d; limit_q <= limit_d; wait_q <= wait_d;
		end
	end

endmodule

// ===== src/spte_back.sv =====
// Back part: queue of result pairs, drained one result beat at a time.
`timescale 1ns / 1ps
module spte_back #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pair_valid,
	output logic                  pair_ready,
	input  spte_pkg::res_pair_t   pair_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output spte_pkg::out_beat_t   out_data
);
	import spte_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	res_pair_t       mem_q [DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [AW:0]     cnt_q;
	logic            sel_q;
	logic            push, pop_beat, pop_pair;
	res_pair_t       head;

	// Pairs with no results are dropped at the door.
	assign pair_ready = (cnt_q != DEPTH[AW:0]);
	assign push       = pair_valid && pair_ready && (pair_data.n != 2'd0);
	assign head       = mem_q[rd_q];
	assign out_valid  = (cnt_q != '0);
	assign out_data   = sel_q ? head.r1 : head.r0;
	assign pop_beat   = out_valid && out_ready;
	assign pop_pair   = pop_beat && (sel_q || (head.n == 2'd1));

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= pair_data;
	end

	// Pointers, fill count and beat select within the head pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0; sel_q <= 1'b0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop_pair) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop_pair};
			if (pop_pair) sel_q <= 1'b0;
			else if (pop_beat) sel_q <= 1'b1;
		end
	end

endmodule

// ===== src/smbus_pec_transaction_engine.sv =====
// Top level of the SMBus host transaction framer with PEC.
`timescale 1ns / 1ps
// SMBus/PMBus host framer with CRC-8 PEC. Event beats are taken while the queue has room;
// each gives up to two result beats, which go into a short queue (QUEUE_DEPTH pairs) and
// leave one beat per cycle while out_ready is high. Zero-result events queue nothing;
// two-result events hold the output for both beats; the output port sets the rate. The
// wait_limit register must be written via cfg_valid/cfg_ready while idle (unchecked).
module smbus_pec_transaction_engine #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  spte_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output spte_pkg::out_beat_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);
	import spte_pkg::*;

	logic        pair_valid, pair_ready;
	res_pair_t   pair_data;
	logic [15:0] wait_limit_q;

	// Configuration register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wait_limit_q <= WAIT_LIMIT_RESET;
		else if (cfg_valid) wait_limit_q <= cfg_data;
	end

	spte_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.wait_limit(wait_limit_q),
		.pair_valid(pair_valid), .pair_ready(pair_ready), .pair_data(pair_data)
	);

	spte_back #(.DEPTH(QUEUE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.pair_valid(pair_valid), .pair_ready(pair_ready), .pair_data(pair_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

endmodule

// ===== verif/testbench.sv =====
// Testbench for the SMBus host transaction framer with PEC checking.
`timescale 1ns / 1ps
module testbench;
	import spte_pkg::*;

	typedef enum logic [3:0] {
		P_IDLE, P_ACK_CMD, P_WAIT_DATA, P_ACK_DATA, P_ACK_PEC, P_RX_COUNT, P_RX_DATA, P_RX_PEC
	} framer_phase_t;

	// Predicts the framer's result beats and checks them in order.
	class pec_framer_scoreboard;
		framer_phase_t phase = P_IDLE;
		logic [2:0] cur_kind = '0;
		logic [6:0] addr = '0;
		logic [7:0] pec = '0;
		logic [7:0] left = '0;
		logic [7:0] lim = '0;
		logic [15:0] ticks = '0;
		logic [15:0] wait_limit = WAIT_LIMIT_RESET;
		out_beat_t pending[$];
		int errors = 0;
		int checked = 0;
		int status_seen[8];

		function logic [7:0] crc_byte(logic [7:0] crc, logic [7:0] b);
			logic [7:0] c;
			c = crc ^ b;
			repeat (8) c = {c[6:0], 1'b0} ^ (c[7] ? 8'h07 : 8'h00);
			return c;
		endfunction

		function void push(logic [1:0] rk, logic [6:0] a, logic rd, logic [8:0] cnt,
				logic stop, logic [7:0] ob, logic [2:0] st, logic lst);
			out_beat_t r;
			r.result_kind = rk;
			r.bus_address = a;
			r.read_direction = rd;
			r.transfer_count = cnt;
			r.auto_stop = stop;
			r.out_byte = ob;
			r.status = st;
			r.last = lst;
			pending.push_back(r);
		endfunction

		function void close_txn(logic [2:0] st);
			push(RK_STATUS, 0, 0, 0, 0, 0, st, 1);
			phase = P_IDLE;
			ticks = '0;
		endfunction

		function void tx_byte(logic [7:0] b, framer_phase_t nxt);
			pec = crc_byte(pec, b);
			push(RK_TX, 0, 0, 0, 0, b, 0, 0);
			phase = nxt;
		endfunction

		function void tx_pec();
			push(RK_TX, 0, 0, 0, 0, pec, 0, 0);
			phase = P_ACK_PEC;
		endfunction

		function void rd_start(logic [8:0] cnt, logic stop, framer_phase_t nxt);
			pec = crc_byte(pec, {addr, 1'b1});
			push(RK_START, addr, 1, cnt, stop, 0, 0, 0);
			phase = nxt;
		endfunction

		// Applies one accepted event beat to the predicted state.
		function void note_event(in_beat_t b);
			logic ack_wait, rx_wait;
			logic [8:0] cnt;
			logic stop;
			ack_wait = phase inside {P_ACK_CMD, P_ACK_DATA, P_ACK_PEC};
			rx_wait = phase inside {P_RX_COUNT, P_RX_DATA, P_RX_PEC};
			case (b.func)
				FUNC_START: begin
					if (phase != P_IDLE) return;
					cur_kind = b.kind;
					addr = b.target_address;
					lim = b.read_limit;
					left = b.block_length;
					ticks = '0;
					pec = crc_byte(8'h00, {b.target_address, 1'b0});
					case (b.kind)
						K_SEND: begin cnt = 2; stop = 1; end
						K_WRBYTE: begin cnt = 3; stop = 1; end
						K_WRWORD: begin cnt = 4; stop = 1; end
						K_BLKWR: begin cnt = b.block_length + 9'd3; stop = 1; end
						K_BWBR: begin cnt = b.block_length + 9'd3; stop = 0; end
						default: begin cnt = 1; stop = 0; end
					endcase
					push(RK_START, b.target_address, 0, cnt, stop, 0, 0, 0);
					tx_byte(b.command_code, P_ACK_CMD);
				end
				FUNC_TICK: begin
					if (!ack_wait && !rx_wait) return;
					ticks = ticks + 16'd1;
					if (ticks >= wait_limit) close_txn(ST_TIMEOUT);
				end
				FUNC_ACK: begin
					if (b.nacked && (ack_wait || rx_wait)) begin
						close_txn(ST_NACK);
						return;
					end
					if (!ack_wait) return;
					ticks = '0;
					if (phase == P_ACK_CMD) begin
						case (cur_kind)
							K_SEND: tx_pec();
							K_WRBYTE: begin left = 1; phase = P_WAIT_DATA; end
							K_WRWORD: begin left = 2; phase = P_WAIT_DATA; end
							K_BLKWR, K_BWBR: tx_byte(left, P_ACK_DATA);
							K_RDBYTE: begin left = 1; rd_start(2, 1, P_RX_DATA); end
							K_RDWORD: begin left = 2; rd_start(3, 1, P_RX_DATA); end
							default: rd_start(1, 0, P_RX_COUNT);
						endcase
					end else if (phase == P_ACK_DATA) begin
						if (left != 0) phase = P_WAIT_DATA;
						else tx_pec();
					end else if (cur_kind == K_BWBR) begin
						// The read half keeps its own PEC, starting at the read address.
						pec = '0;
						rd_start(1, 0, P_RX_COUNT);
					end else begin
						close_txn(ST_OK);
					end
				end
				FUNC_DATA: begin
					if (phase != P_WAIT_DATA) return;
					left = left - 8'd1;
					tx_byte(b.byte_value, P_ACK_DATA);
				end
				FUNC_RX: begin
					if (!rx_wait) return;
					ticks = '0;
					if (phase == P_RX_PEC) begin
						close_txn(b.byte_value == pec ? ST_OK : ST_PEC);
						return;
					end
					pec = crc_byte(pec, b.byte_value);
					if (phase == P_RX_COUNT) begin
						if (b.byte_value > lim) begin
							close_txn(ST_OVERFLOW);
							return;
						end
						left = b.byte_value;
						push(RK_START, addr, 1, b.byte_value + 9'd1, 1, 0, 0, 0);
						phase = (b.byte_value != 0) ? P_RX_DATA : P_RX_PEC;
					end else begin
						push(RK_RXDATA, 0, 0, 0, 0, b.byte_value, 0, 0);
						left = left - 8'd1;
						if (left == 0) phase = P_RX_PEC;
					end
				end
				default: ;
			endcase
		endfunction

		// Compares one result beat against the oldest prediction.
		function void check_result(out_beat_t r);
			out_beat_t e;
			if (pending.size() == 0) begin
				$error("unexpected result beat %p", r);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (r.result_kind == RK_STATUS) status_seen[r.status]++;
			if (r.result_kind !== e.result_kind) begin
				$error("result_kind: expected %0d, got %0d", e.result_kind, r.result_kind);
				errors++;
			end
			if (r.bus_address !== e.bus_address) begin
				$error("bus_address: expected %0d, got %0d", e.bus_address, r.bus_address);
				errors++;
			end
			if (r.read_direction !== e.read_direction) begin
				$error("read_direction: expected %0d, got %0d", e.read_direction,
					r.read_direction);
				errors++;
			end
			if (r.transfer_count !== e.transfer_count) begin
				$error("transfer_count: expected %0d, got %0d", e.transfer_count,
					r.transfer_count);
				errors++;
			end
			if (r.auto_stop !== e.auto_stop) begin
				$error("auto_stop: expected %0d, got %0d", e.auto_stop, r.auto_stop);
				errors++;
			end
			if (r.out_byte !== e.out_byte) begin
				$error("out_byte: expected %0h, got %0h", e.out_byte, r.out_byte);
				errors++;
			end
			if (r.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, r.status);
				errors++;
			end
			if (r.last !== e.last) begin
				$error("last: expected %0d, got %0d", e.last, r.last);
				errors++;
			end
		endfunction
	endclass

	localparam int CYCLE_LIMIT = 600000;
	localparam int ITEMS_PER_PHASE = 260;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	out_beat_t out_data;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;

	pec_framer_scoreboard sb = new();
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int hold_off = 0;
	int cycles = 0;
	int events_sent = 0;

	smbus_pec_transaction_engine dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_off > 0) begin
			out_ready = 0;
			hold_off--;
		end else begin
			out_ready = ($urandom_range(0, 99) >= snk_stall_pct);
		end
	end

	// Result beats are checked at the rising edge they are taken.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
	end

	// Offers one event beat and waits until the framer takes it.
	task automatic send_event(in_beat_t b);
		if ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid = 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid = 1;
		in_data = b;
		do @(posedge clk); while (!in_ready);
		sb.note_event(b);
		events_sent++;
		@(negedge clk);
		in_valid = 0;
	endtask

	// Picks the next event from the predicted phase, with some noise mixed in.
	task automatic next_event(int noise_pct);
		in_beat_t b;
		logic [63:0] r;
		int roll;
		r = {$urandom, $urandom};
		b = r[$bits(in_beat_t)-1:0];
		roll = $urandom_range(0, 99);
		if ($urandom_range(0, 99) >= noise_pct) begin
			case (sb.phase)
				P_IDLE: begin
					b.func = FUNC_START;
					b.block_length = ($urandom_range(0, 299) == 0) ? 8'd255 :
						8'($urandom_range(0, 6));
				end
				P_WAIT_DATA: b.func = FUNC_DATA;
				P_RX_COUNT, P_RX_DATA, P_RX_PEC: begin
					b.func = FUNC_RX;
					if (sb.phase == P_RX_COUNT && roll < 85)
						b.byte_value = 8'($urandom_range(0, sb.lim < 6 ? sb.lim : 6));
					if (sb.phase == P_RX_PEC && roll < 80) b.byte_value = sb.pec;
					if (roll >= 94) begin
						b.func = FUNC_ACK;
						b.nacked = 1;
					end else if (roll >= 88) begin
						b.func = FUNC_TICK;
					end
				end
				default: begin
					b.func = (roll < 10) ? FUNC_TICK : FUNC_ACK;
					b.nacked = (roll >= 94);
				end
			endcase
		end
		send_event(b);
	endtask

	// Directed start beat, optionally followed by a refusal from the target.
	task automatic start_txn(logic [2:0] k, logic [6:0] a, logic [7:0] c, logic refuse);
		in_beat_t b;
		b = '0;
		b.func = FUNC_START;
		b.kind = k;
		b.target_address = a;
		b.command_code = c;
		b.block_length = 8'd1;
		b.read_limit = 8'd255;
		send_event(b);
		if (refuse) begin
			b = '0;
			b.func = FUNC_ACK;
			b.nacked = 1;
			send_event(b);
		end
	endtask

	task automatic drain_txn();
		while (sb.phase != P_IDLE) next_event(0);
	endtask

	task automatic write_wait_limit(logic [15:0] v);
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		cfg_valid = 1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		sb.wait_limit = v;
		@(negedge clk);
		cfg_valid = 0;
	endtask

	initial begin
		in_beat_t b;
		int start_count;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: full send byte at both address extremes, then every other kind refused.
		start_txn(K_SEND, 7'd127, 8'hFF, 0);
		drain_txn();
		start_txn(K_SEND, 7'd0, 8'h00, 0);
		drain_txn();
		for (int k = K_WRBYTE; k <= K_BWBR; k++) start_txn(3'(k), 7'($urandom), 8'hA5, 1);
		b = '0;
		b.func = 3'd7;
		send_event(b);

		// Random phases over several idling patterns and wait limits.
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: begin src_idle_pct = 0; snk_stall_pct = 0; end
				1: begin write_wait_limit(16'hFFFF); src_idle_pct = 74; snk_stall_pct = 0; end
				2: begin write_wait_limit(16'd1); src_idle_pct = 0; snk_stall_pct = 74; end
				3: begin
					write_wait_limit(16'($urandom_range(2, 12)));
					src_idle_pct = 15;
					snk_stall_pct = 15;
				end
				default: begin
					write_wait_limit(WAIT_LIMIT_RESET);
					src_idle_pct = 0;
					snk_stall_pct = 0;
					hold_off = 400;
				end
			endcase
			start_count = events_sent;
			while (events_sent - start_count < ITEMS_PER_PHASE) next_event(8);
			drain_txn();
		end

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Ran %0d event beats and checked %0d result beats.", events_sent, sb.checked);
		$display("Endings: ok %0d, nack %0d, timeout %0d, pec error %0d, overflow %0d.",
			sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
			sb.status_seen[4]);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
